// ===== rtl/core/pdr_pkg.sv =====
package pdr_pkg;

  localparam int MAX_CHANNELS_DEF        = 8;
  localparam int PHASE_FRACTION_BITS_DEF = 16;
  localparam int RESULT_LIMIT            = 8;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 20;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_FORMAT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_RATIO    = 2'd2;

  typedef enum logic [1:0] {
    FMT_FLOAT32,
    FMT_PCM16,
    FMT_PCM24,
    FMT_PCM32
  } fmt_t;

  localparam logic [3:0]  RST_CHANNEL_COUNT = 4'd2;
  localparam logic [19:0] RST_STEP_RATIO    = 20'd196608;

  // Normalised sample: signed Q31, float inputs saturate at +-8.0
  localparam int Q_W = 36;
  localparam logic [34:0] FLOAT_SAT = 35'h4_0000_0000;

  typedef struct packed {
    logic [31:0] sample_word;
    logic        silent;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic               last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic clamp;
    logic scale;
    logic div_step;
    logic emit;
    logic skip;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic phase_ge_half;
    logic out_free;
    logic emit_last;
  } stat_t;

  function automatic logic signed [Q_W-1:0] float_to_q(input logic [31:0] w);
    logic [7:0]  ex;
    logic [22:0] fr;
    logic [23:0] m;
    logic [7:0]  e;
    logic [7:0]  sh;
    logic [34:0] mag;
    ex = w[30:23];
    fr = w[22:0];
    m  = '0;
    e  = '0;
    sh = '0;
    if (ex == 8'hFF && fr != 23'd0) begin
      mag = '0;
    end else if (ex >= 8'd130) begin
      mag = FLOAT_SAT;
    end else begin
      m = (ex == 8'd0) ? {1'b0, fr} : {1'b1, fr};
      e = (ex == 8'd0) ? 8'd1 : ex;
      if (e >= 8'd119) begin
        mag = {11'd0, m} << (e - 8'd119);
      end else begin
        sh  = 8'd119 - e;
        mag = (sh >= 8'd32) ? 35'd0 : ({11'd0, m} >> sh);
      end
    end
    return w[31] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
  endfunction

  function automatic logic signed [Q_W-1:0] to_q(input logic [31:0] w, input fmt_t fmt);
    logic signed [Q_W-1:0] r;
    unique case (fmt)
      FMT_FLOAT32: r = float_to_q(w);
      FMT_PCM16:   r = signed'({{4{w[15]}}, w[15:0], 16'd0});
      FMT_PCM24:   r = signed'({{4{w[23]}}, w[23:0], 8'd0});
      FMT_PCM32:   r = signed'({{4{w[31]}}, w});
      default:     r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/pcm_downmix_resampler.sv =====
// Channel  Handshake            Payload                      Direction
// in       in_valid/in_ready    in_data (sample_word,silent) sink
// out      out_valid/out_ready  out_data (pcm_sample,last)   source
// cfg      cfg_wen              cfg_index, cfg_wdata         sink, no wait
//
// A channel sample that does not end a frame is only added to the running sum.
// The closing sample of a frame goes through clamp, scale and the one-bit-a-cycle
// divider, then the emitter gives one output sample per cycle while the output
// is free (up to eight), or skips the frame when it gives none.
// Synchronous reset, active high, restores register defaults and clears frame and control state.
// A stalled output holds the emitter; input is taken again once the last
// result of the frame sits in the output register, or once a frame gives none.
module pcm_downmix_resampler #(
  parameter int MAX_CHANNELS        = pdr_pkg::MAX_CHANNELS_DEF,
  parameter int PHASE_FRACTION_BITS = pdr_pkg::PHASE_FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pdr_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pdr_pkg::out_item_t              out_data,
  input  logic                            cfg_wen,
  input  logic [pdr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pdr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // numerator width of the divider, one quotient bit per cycle
  localparam int DIV_STEPS = $clog2(MAX_CHANNELS + 1) + 15;

  pdr_pkg::cmd_t  cmd;
  pdr_pkg::stat_t stat;

  pdr_ctrl #(
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  pdr_dpath #(
    .MAX_CHANNELS        (MAX_CHANNELS),
    .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  // more results of the frame follow a transfer straight away
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_of_frame |=> out_valid)
    else $error("result burst broke before last_of_frame");

  // the scaled value never reaches the negative full scale
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.pcm_sample != 16'sh8000)
    else $error("output sample out of range");

  // no output is pending and input is open after reset
  a_reset: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("reset did not open the input");

endmodule

// ===== rtl/core/pdr_ctrl.sv =====
module pdr_ctrl #(
  parameter int DIV_STEPS = 19
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  pdr_pkg::stat_t stat,
  output logic           in_ready,
  output pdr_pkg::cmd_t  cmd
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLAMP,
    S_SCALE,
    S_DIV,
    S_EMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] div_cnt;

  assign cmd.take     = (state == S_IDLE) && in_valid;
  assign cmd.clamp    = (state == S_CLAMP);
  assign cmd.scale    = (state == S_SCALE);
  assign cmd.div_step = (state == S_DIV);
  assign cmd.skip     = (state == S_EMIT) && stat.phase_ge_half;
  assign cmd.emit     = (state == S_EMIT) && !stat.phase_ge_half && stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
      div_cnt  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && stat.frame_end) begin
            state    <= S_CLAMP;
            in_ready <= 1'b0;
          end
        end
        S_CLAMP: state <= S_SCALE;
        S_SCALE: begin
          state   <= S_DIV;
          div_cnt <= '0;
        end
        S_DIV: begin
          div_cnt <= div_cnt + CNT_W'(1);
          if (div_cnt == CNT_W'(DIV_STEPS - 1)) state <= S_EMIT;
        end
        S_EMIT: begin
          if (stat.phase_ge_half || (stat.out_free && stat.emit_last)) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/pdr_dpath.sv =====
module pdr_dpath #(
  parameter int MAX_CHANNELS        = pdr_pkg::MAX_CHANNELS_DEF,
  parameter int PHASE_FRACTION_BITS = pdr_pkg::PHASE_FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [pdr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pdr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  pdr_pkg::in_item_t                in_data,
  input  logic                             out_ready,
  output logic                             out_valid,
  output pdr_pkg::out_item_t               out_data,
  input  pdr_pkg::cmd_t                    cmd,
  output pdr_pkg::stat_t                   stat
);

  localparam int CW     = $clog2(MAX_CHANNELS + 1);
  localparam int SUM_W  = CW + 36;
  localparam int MAG_W  = SUM_W - 1;
  localparam int PROD_W = MAG_W + 15;
  localparam int NUM_W  = CW + 15;
  localparam int PH_W   = PHASE_FRACTION_BITS + 6;
  localparam int N_W    = $clog2(pdr_pkg::RESULT_LIMIT);
  localparam int STW_W  = 20 + PHASE_FRACTION_BITS;

  localparam logic signed [PH_W-1:0] ONE  = signed'(PH_W'(1) << PHASE_FRACTION_BITS);
  localparam logic signed [PH_W-1:0] HALF = signed'(PH_W'(1) << (PHASE_FRACTION_BITS - 1));

  pdr_pkg::fmt_t fmt;
  logic [3:0]    chan_cfg;
  logic [19:0]   ratio;

  logic [CW-1:0]            chans;
  logic [CW-1:0]            idx;
  logic [CW-1:0]            div_c;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  q_ext;
  logic signed [SUM_W-1:0]  lim;
  logic signed [SUM_W-1:0]  s_clamp;
  logic                     mute_acc;
  logic                     mute;
  logic                     neg;
  logic [MAG_W-1:0]         mag;
  logic [PROD_W-1:0]        prod;
  logic [NUM_W-1:0]         num;
  logic [CW-1:0]            rem;
  logic [CW:0]              r2;
  logic                     qbit;
  logic signed [15:0]       q16;
  logic signed [15:0]       val;
  logic [N_W-1:0]           n;
  logic signed [PH_W-1:0]   phase;
  logic signed [PH_W-1:0]   step;
  logic signed [PH_W-1:0]   ph_add;
  logic signed [PH_W-1:0]   ph_final;
  logic [STW_W-1:0]         step_wide;
  logic                     last;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt      <= pdr_pkg::FMT_PCM16;
      chan_cfg <= pdr_pkg::RST_CHANNEL_COUNT;
      ratio    <= pdr_pkg::RST_STEP_RATIO;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        pdr_pkg::REG_SAMPLE_FORMAT: fmt      <= pdr_pkg::fmt_t'(cfg_wdata[1:0]);
        pdr_pkg::REG_CHANNEL_COUNT: chan_cfg <= cfg_wdata[3:0];
        pdr_pkg::REG_STEP_RATIO:    ratio    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (chan_cfg == 4'd0) chans = CW'(1);
    else if (int'(chan_cfg) > MAX_CHANNELS) chans = CW'(MAX_CHANNELS);
    else chans = CW'(chan_cfg);
  end

  assign q_ext = SUM_W'(pdr_pkg::to_q(in_data.sample_word, fmt));
  assign stat.frame_end = ({1'b0, idx} + (CW+1)'(1)) >= {1'b0, chans};

  assign lim     = signed'(SUM_W'(div_c) << 31);
  assign s_clamp = (sum > lim) ? lim : ((sum < -lim) ? -lim : sum);
  assign prod    = {mag, 15'd0} - PROD_W'(mag);

  assign r2   = {rem, num[NUM_W-1]};
  assign qbit = r2 >= {1'b0, div_c};

  assign q16 = signed'(num[15:0]);
  assign val = mute ? 16'sd0 : (neg ? -q16 : q16);

  assign step_wide = {ratio, {PHASE_FRACTION_BITS{1'b0}}} >> 16;
  assign step      = signed'(PH_W'(step_wide));
  assign ph_add    = phase + step;
  assign last      = (ph_add >= HALF) || (n == N_W'(pdr_pkg::RESULT_LIMIT - 1));
  assign ph_final  = ((ph_add < HALF) ? HALF : ph_add) - ONE;

  assign stat.phase_ge_half = phase >= HALF;
  assign stat.out_free      = !out_valid || out_ready;
  assign stat.emit_last     = last;

  // Frame accumulation and control-side state
  always_ff @(posedge clk) begin
    if (rst) begin
      sum      <= '0;
      idx      <= '0;
      mute_acc <= 1'b0;
      phase    <= '0;
      n        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.take) begin
        sum      <= sum + q_ext;
        mute_acc <= mute_acc | in_data.silent;
        idx      <= stat.frame_end ? '0 : idx + CW'(1);
      end
      if (cmd.clamp) begin
        sum      <= '0;
        mute_acc <= 1'b0;
      end
      if (cmd.scale) n <= '0;
      if (cmd.skip) phase <= phase - ONE;
      if (cmd.emit) begin
        phase     <= last ? ph_final : ph_add;
        n         <= n + N_W'(1);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Scaling, divider and output payload
  always_ff @(posedge clk) begin
    if (cmd.take && stat.frame_end) div_c <= chans;
    if (cmd.clamp) begin
      neg  <= s_clamp < 0;
      mag  <= MAG_W'((s_clamp < 0) ? -s_clamp : s_clamp);
      mute <= mute_acc | 1'b0;
    end
    if (cmd.scale) begin
      num <= NUM_W'(prod >> 31);
      rem <= '0;
    end
    if (cmd.div_step) begin
      rem <= qbit ? CW'(r2 - {1'b0, div_c}) : CW'(r2);
      num <= {num[NUM_W-2:0], qbit};
    end
    if (cmd.emit) begin
      out_data.pcm_sample    <= val;
      out_data.last_of_frame <= last;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int FRAC_BITS     = 16;
  localparam int CHAN_CAP      = 8;
  localparam int FRAME_LIMIT   = 8;
  localparam int SETTLE_CYCLES = 64;    // closing sample: clamp, scale and divider plus up to 8 outputs
  localparam int STALL_LIMIT   = 3000;  // cycles with no transfer before giving up
  localparam logic [pdr_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam longint Q31_ONE = 64'sd2147483648;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_ready;
  pdr_pkg::in_item_t               in_data;
  logic                            out_valid;
  logic                            out_ready;
  pdr_pkg::out_item_t              out_data;
  logic                            cfg_wen;
  logic [pdr_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [pdr_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  pcm_downmix_resampler u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the block's registers and frame state
  pdr_pkg::fmt_t mix_fmt;
  logic [3:0]    mix_chans;
  logic [19:0]   mix_ratio;
  longint        mix_sum;
  int            mix_count;
  bit            mix_silent;
  longint        out_phase;

  pdr_pkg::out_item_t pending_pcm[$];

  int errors;
  int samples_sent;
  int pcm_checked;
  int frames_closed;
  int send_idle;
  int recv_idle;
  int hold_cycles;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("%0t  %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // Float bits to signed Q31, saturating at +-8.0
  function automatic longint float_q31(input logic [31:0] w);
    int     ex;
    longint frac;
    longint mant;
    longint mag;
    ex   = w[30:23];
    frac = w[22:0];
    if (ex == 255 && frac != 0) return 0;
    if (ex >= 130) begin
      mag = 64'sd1 << 34;
    end else begin
      mant = (ex == 0) ? frac : (frac | (64'sd1 << 23));
      if (ex == 0) ex = 1;
      if (ex >= 119) mag = mant << (ex - 119);
      else if (119 - ex >= 32) mag = 0;
      else mag = mant >> (119 - ex);
    end
    return w[31] ? -mag : mag;
  endfunction

  function automatic longint sample_q31(input logic [31:0] w, input pdr_pkg::fmt_t f);
    case (f)
      pdr_pkg::FMT_FLOAT32: return float_q31(w);
      pdr_pkg::FMT_PCM16:   return longint'($signed(w[15:0])) * 65536;
      pdr_pkg::FMT_PCM24:   return longint'($signed(w[23:0])) * 256;
      default:              return longint'($signed(w));
    endcase
  endfunction

  function automatic int live_chans();
    if (mix_chans == 0) return 1;
    if (mix_chans > CHAN_CAP) return CHAN_CAP;
    return mix_chans;
  endfunction

  task automatic mirror_reset();
    mix_fmt    = pdr_pkg::FMT_PCM16;
    mix_chans  = pdr_pkg::RST_CHANNEL_COUNT;
    mix_ratio  = pdr_pkg::RST_STEP_RATIO;
    mix_sum    = 0;
    mix_count  = 0;
    mix_silent = 0;
    out_phase  = 0;
  endtask

  // Fold one accepted channel sample in; at frame close queue the outputs
  task automatic absorb_sample(input logic [31:0] w, input logic s);
    int                 chans;
    longint             lim;
    longint             clamped;
    longint             mag;
    longint             stride;
    longint             half;
    int                 n;
    pdr_pkg::out_item_t r;
    chans = live_chans();
    mix_sum += sample_q31(w, mix_fmt);
    if (s) mix_silent = 1;
    mix_count++;
    if (mix_count < chans) return;
    lim     = chans * Q31_ONE;
    clamped = mix_sum;
    if (clamped > lim) clamped = lim;
    if (clamped < -lim) clamped = -lim;
    mag = ((clamped < 0 ? -clamped : clamped) * 32767) / lim;
    r.pcm_sample = mix_silent ? 16'sd0 : 16'(clamped < 0 ? -mag : mag);
    r.last_of_frame = 1'b0;
    stride = (longint'(mix_ratio) << FRAC_BITS) >> 16;
    half   = (64'sd1 << FRAC_BITS) / 2;
    n = 0;
    while (out_phase < half && n < FRAME_LIMIT) begin
      pending_pcm = {pending_pcm, r};
      out_phase += stride;
      n++;
    end
    if (out_phase < half) out_phase = half;  // drop positions past the per-frame cap
    if (n > 0) pending_pcm[$].last_of_frame = 1'b1;
    out_phase -= (64'sd1 << FRAC_BITS);
    mix_sum    = 0;
    mix_count  = 0;
    mix_silent = 0;
    frames_closed++;
  endtask

  // Offer one channel sample; valid stays up across back-to-back transfers
  task automatic send_sample(input logic [31:0] w, input logic s);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{sample_word: w, silent: s};
    do @(posedge clk); while (!in_ready);
    absorb_sample(w, s);
    samples_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pcm.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write a register while idle and keep the mirror in step
  task automatic write_reg(input logic [pdr_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [19:0] val);
    drain();
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      pdr_pkg::REG_SAMPLE_FORMAT: mix_fmt = pdr_pkg::fmt_t'(val[1:0]);
      pdr_pkg::REG_CHANNEL_COUNT: mix_chans = val[3:0];
      pdr_pkg::REG_STEP_RATIO:    mix_ratio = val;
      default: ;
    endcase
  endtask

  task automatic send_frame(input logic [31:0] w, input logic s);
    repeat (live_chans()) send_sample(w, s);
  endtask

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(5))
      0: w = {1'($urandom_range(1)), 8'($urandom_range(100, 140)), 23'($urandom)};
      1: w = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: w = $urandom_range(1) ? 32'h0000_7FFF : 32'h0080_0000;
      3: w = 32'($signed(16'($urandom)) >>> $urandom_range(15));
      default: ;
    endcase
    return w;
  endfunction

  // Extremes of each format, float special values, silence and register corners
  task automatic test_directed();
    send_frame(32'h0000_7FFF, 1'b0);
    send_frame(32'hFFFF_8000, 1'b0);
    send_sample(32'h0000_7FFF, 1'b0);
    send_sample(32'h0000_8000, 1'b1);
    write_reg(pdr_pkg::REG_SAMPLE_FORMAT, pdr_pkg::FMT_FLOAT32);
    write_reg(pdr_pkg::REG_CHANNEL_COUNT, 20'd1);
    send_frame(32'h7F80_0000, 1'b0);  // +inf
    send_frame(32'hFF80_0000, 1'b0);  // -inf
    send_frame(32'h7FC0_0001, 1'b0);  // NaN
    send_frame(32'h0000_0001, 1'b0);  // denormal
    send_frame(32'h3F80_0000, 1'b0);  // 1.0
    send_frame(32'hBF00_0000, 1'b0);  // -0.5
    send_frame(32'h4100_0000, 1'b0);  // 8.0
    send_frame(32'h3000_0000, 1'b0);  // exactly one LSB
    write_reg(pdr_pkg::REG_SAMPLE_FORMAT, pdr_pkg::FMT_PCM24);
    write_reg(pdr_pkg::REG_CHANNEL_COUNT, 20'd0);   // acts as one channel
    send_frame(32'h007F_FFFF, 1'b0);
    send_frame(32'hFF80_0000, 1'b0);
    write_reg(pdr_pkg::REG_SAMPLE_FORMAT, pdr_pkg::FMT_PCM32);
    write_reg(pdr_pkg::REG_CHANNEL_COUNT, 20'd15);  // capped at eight
    send_frame(32'h7FFF_FFFF, 1'b0);
    write_reg(pdr_pkg::REG_STEP_RATIO, 20'd1);      // too many positions: cap and drop
    send_frame(32'h8000_0000, 1'b0);
    write_reg(pdr_pkg::REG_STEP_RATIO, 20'hF_FFFF); // most frames give nothing
    write_reg(REG_SPARE, 20'hF_FFFF);               // ignored
    write_reg(pdr_pkg::REG_CHANNEL_COUNT, 20'd1);
    repeat (4) send_sample(32'h1234_5678, 1'b0);
    write_reg(pdr_pkg::REG_STEP_RATIO, 20'd8192);
    send_sample(32'h8765_4321, 1'b0);
  endtask

  // Mostly whole frames with random content, some stray samples
  task automatic test_random(input int budget);
    int stop;
    stop = samples_sent + budget;
    while (samples_sent < stop) begin
      if ($urandom_range(15) == 0) begin
        write_reg(pdr_pkg::REG_SAMPLE_FORMAT, 20'($urandom_range(3)));
        write_reg(pdr_pkg::REG_CHANNEL_COUNT, 20'($urandom_range(15)));
        write_reg(pdr_pkg::REG_STEP_RATIO, $urandom_range(3) == 0 ? 20'($urandom)
                                           : 20'($urandom_range(8192, 786432)));
      end
      if ($urandom_range(9) == 0) send_sample(pick_word(), 1'($urandom_range(1)));
      else repeat (live_chans()) send_sample(pick_word(), $urandom_range(19) == 0);
    end
  endtask

  // Hold the output off while the sender keeps offering, so input backs up
  task automatic test_backpressure();
    write_reg(pdr_pkg::REG_STEP_RATIO, 20'd8192);
    write_reg(pdr_pkg::REG_CHANNEL_COUNT, 20'd1);
    hold_cycles = 400;
    repeat (40) send_sample(pick_word(), 1'b0);
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Compare each output transfer with the oldest pending result
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_pcm.size() == 0) begin
        report_mismatch("unexpected output", out_data.pcm_sample, 0);
      end else begin
        if (out_data.pcm_sample !== pending_pcm[0].pcm_sample)
          report_mismatch("pcm_sample", out_data.pcm_sample, pending_pcm[0].pcm_sample);
        if (out_data.last_of_frame !== pending_pcm[0].last_of_frame)
          report_mismatch("last_of_frame", out_data.last_of_frame,
                          pending_pcm[0].last_of_frame);
        void'(pending_pcm.pop_front());
      end
      pcm_checked++;
    end
  end

  // Watchdog: count cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("pcm_downmix_resampler: mismatch");
      $finish;
    end
  end

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    in_data      <= '0;
    cfg_wen      <= 1'b0;
    cfg_index    <= '0;
    cfg_wdata    <= '0;
    out_ready    <= 1'b0;
    errors       = 0;
    samples_sent = 0;
    pcm_checked  = 0;
    frames_closed = 0;
    hold_cycles  = 0;
    quiet_cycles = 0;
    send_idle    = 0;
    recv_idle    = 0;
    mirror_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    send_idle = 34; recv_idle = 85;
    test_random(125);
    send_idle = 85; recv_idle = 34;
    test_random(125);
    send_idle = 0; recv_idle = 0;
    test_random(125);
    test_backpressure();
    drain();

    $display("Covered %0d channel samples in %0d frames, %0d output samples checked,",
             samples_sent, frames_closed, pcm_checked);
    $display("all four formats, channel counts 0 to 15, step extremes and a long stall.");
    if (errors == 0) begin
      $display("pcm_downmix_resampler: match");
    end else begin
      $display("pcm_downmix_resampler: mismatch");
    end
    $finish;
  end

endmodule
